### src/fla_pkg.sv
// Shared types, codes and widths for the free-list slot allocator.
package fla_pkg;

    // Default pool size, stub slot included
    localparam int SLOTS_DEF = 1024;

    // Fixed field widths
    localparam int CMD_W  = 2;
    localparam int IDX_W  = 10;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    // Request codes (any other code is served as a query)
    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DEAD    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd3;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } fsm_state_t;

    // One result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  result_index;
        logic              slot_alive;
        logic [CNT_W-1:0]  live_count;
    } result_t;

endpackage

### src/free_list_slot_allocator.sv
// Top level of the free-list slot allocator.
//
//  channel  direction  handshake              payload
//  cfg      in         cfg_valid / cfg_ready  cfg_data (capacity)
//  in       in         in_valid / in_ready    cmd, slot_index
//  out      out        out_valid / out_ready  status, result_index, slot_alive, live_count
//
// Each item reads the slot store, then is updated and written back.
// One item is in flight at a time; the head pointer of the next allocate depends on it.
// After reset a clearing pass sweeps every slot of the store; no item is accepted
// then, while capacity writes are taken at all times.
// A result waiting in the output register does not block the next item's read;
// only its write-back cycle waits for room.
module free_list_slot_allocator #(
    parameter int SLOTS = fla_pkg::SLOTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [fla_pkg::CNT_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [fla_pkg::CMD_W-1:0]    cmd,
    input  logic [fla_pkg::IDX_W-1:0]    slot_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fla_pkg::STAT_W-1:0]   status,
    output logic [fla_pkg::IDX_W-1:0]    result_index,
    output logic                         slot_alive,
    output logic [fla_pkg::CNT_W-1:0]    live_count
);

    localparam int AW = $clog2(SLOTS);
    localparam int DW = AW + 2;

    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [DW-1:0]    mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [DW-1:0]    mem_rdata;
    logic             res_valid;
    logic             res_ready;
    fla_pkg::result_t res;

    fla_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .slot_index (slot_index),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    fla_slot_ram #(
        .DEPTH  (SLOTS),
        .DATA_W (DW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    fla_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_index (result_index),
        .slot_alive   (slot_alive),
        .live_count   (live_count)
    );

    // One item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted while previous item still in flight");

    // Controller pushes a result only into free room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result pushed into a full output stage");

    // Store read and write never share a cycle
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("slot store read and write in the same cycle");

    // A failed allocate grants nothing
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == fla_pkg::STAT_FULL
        |-> res.result_index == '0 && !res.slot_alive && !mem_we)
        else $error("pool-full result grants a slot");

endmodule

### src/fla_slot_ram.sv
// Slot store: one write port, one read port with registered read data.
module fla_slot_ram #(
    parameter int DEPTH  = fla_pkg::SLOTS_DEF,
    parameter int DATA_W = 12
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/fla_ctrl.sv
// Allocator control: clearing sweep, request decode, read-modify-write of the slot store.
module fla_ctrl #(
    parameter int SLOTS = fla_pkg::SLOTS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // capacity register write
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [fla_pkg::CNT_W-1:0]   cfg_data,
    // request side
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [fla_pkg::CMD_W-1:0]   cmd,
    input  logic [fla_pkg::IDX_W-1:0]   slot_index,
    // slot store
    output logic                        mem_we,
    output logic [$clog2(SLOTS)-1:0]    mem_waddr,
    output logic [$clog2(SLOTS)+1:0]    mem_wdata,
    output logic                        mem_re,
    output logic [$clog2(SLOTS)-1:0]    mem_raddr,
    input  logic [$clog2(SLOTS)+1:0]    mem_rdata,
    // result side
    output logic                        res_valid,
    input  logic                        res_ready,
    output fla_pkg::result_t            res
);

    localparam int AW = $clog2(SLOTS);
    localparam int PW = AW + 1;

    fla_pkg::fsm_state_t state_reg, state_next;

    logic [AW-1:0]                clr_cnt_reg, clr_cnt_next;
    logic [PW-1:0]                head_reg, head_next;
    logic [PW-1:0]                hw_reg, hw_next;
    logic [PW-1:0]                count_reg, count_next;
    logic [fla_pkg::CNT_W-1:0]    capacity_reg;
    logic [fla_pkg::CMD_W-1:0]    cmd_reg;
    logic [fla_pkg::IDX_W-1:0]    idx_reg;

    logic          rd_alive;
    logic [PW-1:0] rd_link;
    logic          pool_full;
    logic          idx_oob;
    logic [PW-1:0] count_inc;
    logic [PW-1:0] count_dec;

    assign rd_alive  = mem_rdata[PW];
    assign rd_link   = mem_rdata[PW-1:0];
    assign count_inc = PW'(count_reg + 1'b1);
    assign count_dec = PW'(count_reg - 1'b1);

    // Full when the live count reaches min(capacity, SLOTS) or the head ran off the pool
    assign pool_full = (32'(count_reg) >= 32'(capacity_reg))
                    || (32'(count_reg) >= 32'(SLOTS))
                    || (32'(head_reg) >= 32'(SLOTS));
    assign idx_oob   = 32'(idx_reg) >= 32'(SLOTS);

    // Capacity register takes a write in any cycle
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= fla_pkg::CAP_RESET;
        end
        else if (cfg_valid)
        begin
            capacity_reg <= cfg_data;
        end
    end

    // State and pool pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= fla_pkg::ST_CLEAR;
            clr_cnt_reg <= '0;
            head_reg    <= PW'(1);
            hw_reg      <= PW'(1);
            count_reg   <= PW'(1);
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            hw_reg      <= hw_next;
            count_reg   <= count_next;
        end
    end

    // Latch the request on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            idx_reg <= slot_index;
        end
    end

    // Next state, store accesses and result
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        head_next    = head_reg;
        hw_next      = hw_reg;
        count_next   = count_reg;
        in_ready     = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = '0;
        mem_wdata    = '0;
        mem_re       = 1'b0;
        mem_raddr    = AW'(slot_index);
        res_valid    = 1'b0;
        res          = '0;

        case (state_reg)
            fla_pkg::ST_CLEAR:
            begin
                // sweep the store, dropping every alive bit
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = AW'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == AW'(SLOTS - 1))
                begin
                    state_next = fla_pkg::ST_IDLE;
                end
            end

            fla_pkg::ST_IDLE:
            begin
                // issue the read: head slot on allocate, named slot otherwise
                in_ready = 1'b1;
                if (cmd == fla_pkg::CMD_ALLOC)
                begin
                    mem_raddr = head_reg[AW-1:0];
                end
                if (in_valid)
                begin
                    mem_re     = 1'b1;
                    state_next = fla_pkg::ST_EXEC;
                end
            end

            fla_pkg::ST_EXEC:
            begin
                res.result_index = idx_reg;
                res.live_count   = fla_pkg::CNT_W'(count_reg);
                case (cmd_reg)
                    fla_pkg::CMD_ALLOC:
                    begin
                        res.result_index = '0;
                        if (pool_full)
                        begin
                            res.status = fla_pkg::STAT_FULL;
                        end
                        else
                        begin
                            // take the head; a fresh slot advances the mark
                            res.status       = fla_pkg::STAT_OK;
                            res.result_index = fla_pkg::IDX_W'(head_reg);
                            res.slot_alive   = 1'b1;
                            res.live_count   = fla_pkg::CNT_W'(count_inc);
                            mem_waddr        = head_reg[AW-1:0];
                            mem_wdata        = {1'b1, rd_link};
                            if (head_reg == hw_reg)
                            begin
                                head_next = PW'(head_reg + 1'b1);
                                hw_next   = PW'(hw_reg + 1'b1);
                            end
                            else
                            begin
                                head_next = rd_link;
                            end
                        end
                    end

                    fla_pkg::CMD_FREE:
                    begin
                        if (idx_oob)
                        begin
                            res.status = fla_pkg::STAT_INVALID;
                        end
                        else if (!rd_alive)
                        begin
                            res.status = fla_pkg::STAT_DEAD;
                        end
                        else
                        begin
                            // push the slot onto the free list
                            res.status     = fla_pkg::STAT_OK;
                            res.live_count = fla_pkg::CNT_W'(count_dec);
                            mem_waddr      = AW'(idx_reg);
                            mem_wdata      = {1'b0, head_reg};
                            head_next      = PW'(idx_reg);
                        end
                    end

                    default:
                    begin
                        // query
                        res.slot_alive = rd_alive && !idx_oob;
                        if (idx_reg == '0 || 32'(idx_reg) >= 32'(hw_reg) || idx_oob)
                        begin
                            res.status = fla_pkg::STAT_INVALID;
                        end
                        else
                        begin
                            res.status = fla_pkg::STAT_OK;
                        end
                    end
                endcase

                // commit only when the output stage has room
                if (res_ready)
                begin
                    res_valid  = 1'b1;
                    state_next = fla_pkg::ST_IDLE;
                    if (res.status == fla_pkg::STAT_OK && cmd_reg == fla_pkg::CMD_ALLOC)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_inc;
                    end
                    else if (res.status == fla_pkg::STAT_OK && cmd_reg == fla_pkg::CMD_FREE)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_dec;
                    end
                end
                else
                begin
                    head_next = head_reg;
                    hw_next   = hw_reg;
                end
            end

            default:
            begin
                state_next = fla_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/fla_out_stage.sv
// Output register holding one result item until the consumer takes it.
module fla_out_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         res_valid,
    output logic                         res_ready,
    input  fla_pkg::result_t             res,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [fla_pkg::STAT_W-1:0]   status,
    output logic [fla_pkg::IDX_W-1:0]    result_index,
    output logic                         slot_alive,
    output logic [fla_pkg::CNT_W-1:0]    live_count
);

    logic             valid_reg;
    fla_pkg::result_t data_reg;

    // Room when empty or when the held item leaves this cycle
    assign res_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    // Load the payload with the item
    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign out_valid    = valid_reg;
    assign status       = data_reg.status;
    assign result_index = data_reg.result_index;
    assign slot_alive   = data_reg.slot_alive;
    assign live_count   = data_reg.live_count;

endmodule
